@@ hw/rtl/nprs_pkg.sv @@
// Shared types and constants for the nearest point remove store.
// No dependencies; imported by nearest_point_remove_store_core.
package nprs_pkg;

  // Default sizes
  localparam int unsigned STORE_DEPTH_DEF = 256;
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Item kinds on the input tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Result status codes on the output tuser
  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REMOVED  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

@@ hw/rtl/nearest_point_remove_store_core.sv @@
// Nearest point remove store: two point stores in one synchronous memory,
// a scan pipeline for the nearest point and a compaction sweep.
// Depends on nprs_pkg.
//
// Usage:
//   Input beats (s_*) carry an insert or a remove request: tuser holds the
//   kind and the store select, tdata the point or query coordinates.
//   Output beats (m_*) carry one result per request: tuser holds the status,
//   tdata the removed point (zero unless removed) and the points left.
//   Insert: the point is appended at the store's fill count; the result
//   passes through the emit state into the output register, and no new
//   request is taken until that result is loaded.
//   Remove: the store is read one entry per cycle from memory while a
//   four-stage pipeline (read, difference, square, sum and compare) keeps
//   the nearest entry; the entries after it are then moved down one place,
//   one per cycle through the same memory. After the sweep the result goes
//   through the emit state into the output register; the next request is
//   taken only after that load.
//   An empty store or a full store answers without a scan or a write.
//   One request is worked at a time. The output register lets the next
//   request start while a result waits for m_tready; a stalled receiver
//   holds the block only when a second result is ready.
//   Reset clears both fill counts and the output valid; no clearing pass.
module nearest_point_remove_store_core
  import nprs_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned CNT_W      = $clog2(STORE_DEPTH + 1),
  localparam int unsigned IN_W       = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((3 * COORD_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // px, py, pz, zero pad
  input  logic [1:0]       s_tuser,   // op, which_set
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // nx, ny, nz, remaining, zero pad
  output logic [1:0]       m_tuser    // status
);

  localparam int unsigned CW        = COORD_WIDTH;
  localparam int unsigned PT_W      = 3 * CW;
  localparam int unsigned IDX_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned ADDR_W    = IDX_W + 1;
  localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;
  localparam int unsigned DF_W      = CW + 1;
  localparam int unsigned SQ_W      = 2 * CW + 1;
  localparam int unsigned DIST_W    = SQ_W + 2;

  // Point memory: store select in the top address bit
  logic [PT_W-1:0]   mem [MEM_DEPTH];
  logic              rd_en;
  logic [ADDR_W-1:0] raddr;
  logic [PT_W-1:0]   rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [PT_W-1:0]   wdata;

  state_t state, state_next;

  logic [CNT_W-1:0] cnt [2];
  logic             sel;
  logic [CNT_W-1:0] num;
  logic [PT_W-1:0]  query;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] sh_j;
  logic             sh_v;
  logic [IDX_W-1:0] sh_idx;

  // Scan pipeline stages
  logic                    p0_v, p1_v, p2_v;
  logic [IDX_W-1:0]        p0_idx, p1_idx, p2_idx;
  logic [PT_W-1:0]         p1_pt, p2_pt;
  logic signed [DF_W-1:0]  p1_d [3];
  logic [SQ_W-1:0]         p2_sq [3];

  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  logic [PT_W-1:0]   best_pt;

  // Pending result
  status_t          res_status;
  logic [PT_W-1:0]  res_pt;
  logic [CNT_W-1:0] res_remaining;

  logic             in_op;
  logic             in_sel;
  logic [CNT_W-1:0] in_cnt;
  logic             accept;
  logic             out_load;
  logic [DIST_W-1:0] dist_sum;

  assign in_op    = s_tuser[0];
  assign in_sel   = s_tuser[1];
  assign in_cnt   = cnt[in_sel];
  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // Memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Write port: insert append or compaction move
  always_comb begin
    we    = 1'b0;
    waddr = {sel, sh_idx - IDX_W'(1)};
    wdata = rdata;
    if (accept && op_t'(in_op) == OP_INSERT && in_cnt != CNT_W'(STORE_DEPTH)) begin
      we    = 1'b1;
      waddr = {in_sel, in_cnt[IDX_W-1:0]};
      wdata = s_tdata[PT_W-1:0];
    end else if (sh_v) begin
      we = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory read control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    raddr      = {sel, scan_idx[IDX_W-1:0]};
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (op_t'(in_op) == OP_REMOVE && in_cnt != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx == num - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p0_v && !p1_v && !p2_v) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sh_j < num) begin
          rd_en = 1'b1;
          raddr = {sel, sh_j[IDX_W-1:0]};
        end else if (!sh_v) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0] <= '0;
      cnt[1] <= '0;
    end else if (accept && op_t'(in_op) == OP_INSERT && in_cnt != CNT_W'(STORE_DEPTH)) begin
      cnt[in_sel] <= in_cnt + CNT_W'(1);
    end else if (state == ST_DRAIN && state_next == ST_SHIFT) begin
      cnt[sel] <= num - CNT_W'(1);
    end
  end

  // Capture the request and form quick results
  always_ff @(posedge clk) begin
    if (accept) begin
      sel      <= in_sel;
      num      <= in_cnt;
      query    <= s_tdata[PT_W-1:0];
      scan_idx <= '0;
      res_pt   <= '0;
      if (op_t'(in_op) == OP_INSERT) begin
        if (in_cnt == CNT_W'(STORE_DEPTH)) begin
          res_status    <= STAT_FULL;
          res_remaining <= in_cnt;
        end else begin
          res_status    <= STAT_INSERTED;
          res_remaining <= in_cnt + CNT_W'(1);
        end
      end else begin
        res_status    <= STAT_EMPTY;
        res_remaining <= '0;
      end
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end else if (state == ST_DRAIN && state_next == ST_SHIFT) begin
      res_status    <= STAT_REMOVED;
      res_pt        <= best_pt;
      res_remaining <= num - CNT_W'(1);
    end
  end

  // Scan pipeline: read, difference, square, sum and keep the nearest
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p0_v <= (state == ST_SCAN);
      p1_v <= p0_v;
      p2_v <= p1_v;
    end
  end

  assign dist_sum = DIST_W'(p2_sq[0]) + DIST_W'(p2_sq[1]) + DIST_W'(p2_sq[2]);

  always_ff @(posedge clk) begin
    logic signed [2*DF_W-1:0] prod;
    p0_idx <= scan_idx[IDX_W-1:0];
    p1_idx <= p0_idx;
    p1_pt  <= rdata;
    for (int k = 0; k < 3; k++) begin
      p1_d[k] <= $signed({rdata[k*CW+CW-1], rdata[k*CW +: CW]})
               - $signed({query[k*CW+CW-1], query[k*CW +: CW]});
    end
    p2_idx <= p1_idx;
    p2_pt  <= p1_pt;
    for (int k = 0; k < 3; k++) begin
      prod     = p1_d[k] * p1_d[k];
      p2_sq[k] <= prod[SQ_W-1:0];
    end
    // Strict compare keeps the earliest point on a tie
    if (p2_v && (p2_idx == '0 || dist_sum < best_dist)) begin
      best_dist <= dist_sum;
      best_idx  <= p2_idx;
      best_pt   <= p2_pt;
    end
  end

  // Compaction sweep: read entry j, write it to j - 1 in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_v <= 1'b0;
    end else begin
      sh_v <= (state == ST_SHIFT) && (sh_j < num);
    end
  end

  always_ff @(posedge clk) begin
    sh_idx <= sh_j[IDX_W-1:0];
    if (state == ST_DRAIN) begin
      sh_j <= CNT_W'(best_idx) + CNT_W'(1);
    end else if (state == ST_SHIFT && sh_j < num) begin
      sh_j <= sh_j + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= OUT_W'({res_remaining, res_pt});
    end
  end

endmodule
